// File: rtl/cct_pkg.sv
package cct_pkg;

	// Samples are taken and results given at this width, sign-extended to 32 bits
	localparam int SAMPLE_W = 32;
	localparam int PORT_W   = 32;

	// Q13 rounded products
	localparam int Q_SHIFT  = 13;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = PORT_W + COEF_W;
	localparam logic signed [PROD_W-1:0] Q_HALF = PROD_W'(1) <<< (Q_SHIFT - 1);

	// Forward ICT coefficients
	localparam logic signed [COEF_W-1:0] C_YR = 16'sd2449;
	localparam logic signed [COEF_W-1:0] C_YG = 16'sd4809;
	localparam logic signed [COEF_W-1:0] C_YB = 16'sd934;
	localparam logic signed [COEF_W-1:0] C_UR = 16'sd1382;
	localparam logic signed [COEF_W-1:0] C_UG = 16'sd2714;
	localparam logic signed [COEF_W-1:0] C_UB = 16'sd4096;
	localparam logic signed [COEF_W-1:0] C_VR = 16'sd4096;
	localparam logic signed [COEF_W-1:0] C_VG = 16'sd3430;
	localparam logic signed [COEF_W-1:0] C_VB = 16'sd666;

	// Inverse ICT coefficients (1.402, 0.34413, 0.71414, 1.772 in Q13)
	localparam logic signed [COEF_W-1:0] C_RV = 16'sd11485;
	localparam logic signed [COEF_W-1:0] C_GU = 16'sd2819;
	localparam logic signed [COEF_W-1:0] C_GV = 16'sd5850;
	localparam logic signed [COEF_W-1:0] C_BU = 16'sd14516;

	// Three product slots for each of the three components
	localparam int N_SLOT = 3;

	typedef enum logic [1:0] {
		FUNC_RCT_FWD,
		FUNC_RCT_INV,
		FUNC_ICT_FWD,
		FUNC_ICT_INV
	} func_t;

	// Keep the low SAMPLE_W bits and sign-extend them to the port width
	function automatic logic signed [PORT_W-1:0] to_sample(input logic [PORT_W-1:0] x);
		logic signed [PORT_W-1:0] s;
		s = $signed(x << (PORT_W - SAMPLE_W));
		return s >>> (PORT_W - SAMPLE_W);
	endfunction

endpackage

// File: rtl/cct_qmul.sv
module cct_qmul (
	input  logic signed [cct_pkg::PORT_W-1:0] x,
	input  logic signed [cct_pkg::COEF_W-1:0] coef,
	output logic signed [cct_pkg::PORT_W-1:0] p
);

	logic signed [cct_pkg::PROD_W-1:0] full;
	logic signed [cct_pkg::PROD_W-1:0] rounded;

	// Form the full product, add half an LSB, drop the fraction
	assign full    = cct_pkg::PROD_W'(x) * cct_pkg::PROD_W'(coef);
	assign rounded = full + cct_pkg::Q_HALF;
	assign p       = rounded[cct_pkg::Q_SHIFT+cct_pkg::PORT_W-1:cct_pkg::Q_SHIFT];

endmodule

// File: rtl/component_color_transform_core.sv
// Channel   Handshake        Fields
// command   start / busy     func, comp_a, comp_b, comp_c, last_sample
// result    done (strobe)    res_a, res_b, res_c, last_out
//
// One pixel is taken every cycle; busy stays low.
// The pipeline has three registers: input register, Q13 product register, result register.
// The product stage (nine 32 x 16 multipliers) sets the cycle time.
// Reset clears the valid chain only; no results are given until new commands arrive.
// Each result is shown for one cycle with done high and cannot be held off.
module component_color_transform_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         func,
	input  logic signed [cct_pkg::PORT_W-1:0]  comp_a,
	input  logic signed [cct_pkg::PORT_W-1:0]  comp_b,
	input  logic signed [cct_pkg::PORT_W-1:0]  comp_c,
	input  logic                               last_sample,
	output logic                               done,
	output logic signed [cct_pkg::PORT_W-1:0]  res_a,
	output logic signed [cct_pkg::PORT_W-1:0]  res_b,
	output logic signed [cct_pkg::PORT_W-1:0]  res_c,
	output logic                               last_out
);

	localparam int W = cct_pkg::PORT_W;
	localparam int S = cct_pkg::N_SLOT;

	// Stage 1: input register
	logic                  valid_s1;
	cct_pkg::func_t        func_s1;
	logic signed [W-1:0]   a_s1, b_s1, c_s1;
	logic                  last_s1;

	// Stage 2: product register
	logic                  valid_s2;
	cct_pkg::func_t        func_s2;
	logic signed [W-1:0]   a_s2, b_s2, c_s2;
	logic                  last_s2;
	logic signed [W-1:0]   pa_s2 [S];
	logic signed [W-1:0]   pb_s2 [S];
	logic signed [W-1:0]   pc_s2 [S];

	// Result register
	logic                  done_q;
	logic signed [W-1:0]   ra_q, rb_q, rc_q;
	logic                  last_q;

	logic signed [cct_pkg::COEF_W-1:0] ka [S];
	logic signed [cct_pkg::COEF_W-1:0] kb [S];
	logic signed [cct_pkg::COEF_W-1:0] kc [S];
	logic signed [W-1:0]   pa [S];
	logic signed [W-1:0]   pb [S];
	logic signed [W-1:0]   pc [S];
	logic signed [W-1:0]   ra, rb, rc, t_inv;

	assign busy = 1'b0;

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	// Capture a command transfer
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1 <= cct_pkg::func_t'(func);
			a_s1    <= cct_pkg::to_sample(comp_a);
			b_s1    <= cct_pkg::to_sample(comp_b);
			c_s1    <= cct_pkg::to_sample(comp_c);
			last_s1 <= last_sample;
		end
	end

	// Pick coefficients for each product slot
	always_comb begin
		ka[0] = cct_pkg::C_YR;
		ka[1] = cct_pkg::C_UR;
		ka[2] = cct_pkg::C_VR;
		kb[0] = cct_pkg::C_YG;
		kb[1] = cct_pkg::C_UG;
		kb[2] = cct_pkg::C_VG;
		kc[0] = cct_pkg::C_YB;
		kc[1] = cct_pkg::C_UB;
		kc[2] = cct_pkg::C_VB;
		if (func_s1 == cct_pkg::FUNC_ICT_INV) begin
			kb[0] = cct_pkg::C_GU;
			kb[1] = cct_pkg::C_BU;
			kc[0] = cct_pkg::C_RV;
			kc[1] = cct_pkg::C_GV;
		end
	end

	for (genvar i = 0; i < S; i++) begin : g_slot
		cct_qmul u_qa (.x(a_s1), .coef(ka[i]), .p(pa[i]));
		cct_qmul u_qb (.x(b_s1), .coef(kb[i]), .p(pb[i]));
		cct_qmul u_qc (.x(c_s1), .coef(kc[i]), .p(pc[i]));
	end

	// Hold products and samples for the combine stage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			func_s2 <= func_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			last_s2 <= last_s1;
			pa_s2   <= pa;
			pb_s2   <= pb;
			pc_s2   <= pc;
		end
	end

	// Combine into the three result components
	always_comb begin
		t_inv = a_s2 - ((b_s2 + c_s2) >>> 2);
		case (func_s2)
			cct_pkg::FUNC_RCT_FWD: begin
				ra = (a_s2 + b_s2 + b_s2 + c_s2) >>> 2;
				rb = c_s2 - b_s2;
				rc = a_s2 - b_s2;
			end
			cct_pkg::FUNC_RCT_INV: begin
				ra = c_s2 + t_inv;
				rb = t_inv;
				rc = b_s2 + t_inv;
			end
			cct_pkg::FUNC_ICT_FWD: begin
				ra = pa_s2[0] + pb_s2[0] + pc_s2[0];
				rb = pc_s2[1] - pa_s2[1] - pb_s2[1];
				rc = pa_s2[2] - pb_s2[2] - pc_s2[2];
			end
			default: begin
				ra = a_s2 + pc_s2[0];
				rb = a_s2 - pb_s2[0] - pc_s2[1];
				rc = a_s2 + pb_s2[1];
			end
		endcase
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			ra_q   <= cct_pkg::to_sample(ra);
			rb_q   <= cct_pkg::to_sample(rb);
			rc_q   <= cct_pkg::to_sample(rc);
			last_q <= last_s2;
		end
	end

	assign done     = done_q;
	assign res_a    = ra_q;
	assign res_b    = rb_q;
	assign res_c    = rc_q;
	assign last_out = last_q;

`ifndef SYNTHESIS
	a_cmd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("command transfer gave no result three cycles on");

	a_result_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching command");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_sample, 3)))
		else $error("last flag does not follow its command");

	a_rct_fwd_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(func, 3) == cct_pkg::FUNC_RCT_FWD)) |->
		(res_b == cct_pkg::to_sample(cct_pkg::to_sample($past(comp_c, 3))
			- cct_pkg::to_sample($past(comp_b, 3)))))
		else $error("forward RCT chroma difference mismatch");
`endif

endmodule

// File: verif/cct_pixel_checker.sv
`timescale 1ns / 1ps

module cct_pixel_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 func,
	input  logic [cct_pkg::PORT_W-1:0] comp_a,
	input  logic [cct_pkg::PORT_W-1:0] comp_b,
	input  logic [cct_pkg::PORT_W-1:0] comp_c,
	input  logic                       last_sample,
	input  logic                       done,
	input  logic [cct_pkg::PORT_W-1:0] res_a,
	input  logic [cct_pkg::PORT_W-1:0] res_b,
	input  logic [cct_pkg::PORT_W-1:0] res_c,
	input  logic                       last_out,
	output int                         mismatches,
	output int                         pending,
	output int                         results_seen
);
	import cct_pkg::*;

	typedef struct packed {
		logic [PORT_W-1:0] a;
		logic [PORT_W-1:0] b;
		logic [PORT_W-1:0] c;
		logic              last;
	} pixel_t;

	pixel_t expected_pixels[$];

	// Wrap to the sample width, then sign-extend back to the port width
	function automatic logic [PORT_W-1:0] wrap_sample(input logic [PORT_W-1:0] x);
		logic [PORT_W-1:0] r;
		r = x;
		for (int i = SAMPLE_W; i < PORT_W; i++)
			r[i] = x[SAMPLE_W-1];
		return r;
	endfunction

	// Rounded Q13 product at 64 bits, low 32 bits kept
	function automatic logic [PORT_W-1:0] q13_mul(input logic [PORT_W-1:0] x,
			input logic signed [COEF_W-1:0] coef);
		logic signed [63:0] prod;
		logic signed [63:0] scaled;
		prod   = longint'($signed(x)) * longint'(coef) + longint'(Q_HALF);
		scaled = prod >>> Q_SHIFT;
		return scaled[PORT_W-1:0];
	endfunction

	function automatic logic [PORT_W-1:0] sar2(input logic [PORT_W-1:0] x);
		return $signed(x) >>> 2;
	endfunction

	// Work out the transformed pixel for one command
	function automatic pixel_t transform_pixel(input logic [1:0] code,
			input logic [PORT_W-1:0] in_a, input logic [PORT_W-1:0] in_b,
			input logic [PORT_W-1:0] in_c, input logic last);
		logic [PORT_W-1:0] a, b, c;
		pixel_t px;
		a = wrap_sample(in_a);
		b = wrap_sample(in_b);
		c = wrap_sample(in_c);
		case (func_t'(code))
			FUNC_RCT_FWD: begin
				px.a = sar2(a + b + b + c);
				px.b = c - b;
				px.c = a - b;
			end
			FUNC_RCT_INV: begin
				px.b = a - sar2(b + c);
				px.a = c + px.b;
				px.c = b + px.b;
			end
			FUNC_ICT_FWD: begin
				px.a = q13_mul(a, C_YR) + q13_mul(b, C_YG) + q13_mul(c, C_YB);
				px.b = 0 - q13_mul(a, C_UR) - q13_mul(b, C_UG) + q13_mul(c, C_UB);
				px.c = q13_mul(a, C_VR) - q13_mul(b, C_VG) - q13_mul(c, C_VB);
			end
			default: begin
				px.a = a + q13_mul(c, C_RV);
				px.b = a - q13_mul(b, C_GU) - q13_mul(c, C_GV);
				px.c = a + q13_mul(b, C_BU);
			end
		endcase
		px.a    = wrap_sample(px.a);
		px.b    = wrap_sample(px.b);
		px.c    = wrap_sample(px.c);
		px.last = last;
		return px;
	endfunction

	task automatic compare_field(input string name, input logic [PORT_W-1:0] want,
			input logic [PORT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	initial begin
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
	end

	// Compare each result transfer first, then queue the prediction for a new command
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: result with no command outstanding, actual %h %h %h %b",
						$time, res_a, res_b, res_c, last_out);
				end else begin
					want = expected_pixels.pop_front();
					compare_field("res_a", want.a, res_a);
					compare_field("res_b", want.b, res_b);
					compare_field("res_c", want.c, res_c);
					compare_field("last_out", PORT_W'(want.last), PORT_W'(last_out));
				end
			end
			if (start && !busy)
				expected_pixels.push_back(transform_pixel(func, comp_a, comp_b, comp_c,
					last_sample));
			pending = expected_pixels.size();
		end
	end

endmodule

// File: verif/component_color_transform_core_tb.sv
`timescale 1ns / 1ps

module component_color_transform_core_tb;
	import cct_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1600;
	localparam logic [PORT_W-1:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [PORT_W-1:0] S_MIN = 32'h8000_0000;
	localparam logic [PORT_W-1:0] S_NEG1 = 32'hFFFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        func;
	logic [PORT_W-1:0] comp_a, comp_b, comp_c;
	logic              last_sample;
	logic              done;
	logic [PORT_W-1:0] res_a, res_b, res_c;
	logic              last_out;

	int mismatches, pending, results_seen;
	int idle_pct;
	int idle_cycles;
	int stall_count;
	int func_count[4];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	component_color_transform_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.comp_a      (comp_a),
		.comp_b      (comp_b),
		.comp_c      (comp_c),
		.last_sample (last_sample),
		.done        (done),
		.res_a       (res_a),
		.res_b       (res_b),
		.res_c       (res_c),
		.last_out    (last_out)
	);

	cct_pixel_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.comp_a       (comp_a),
		.comp_b       (comp_b),
		.comp_c       (comp_c),
		.last_sample  (last_sample),
		.done         (done),
		.res_a        (res_a),
		.res_b        (res_b),
		.res_c        (res_c),
		.last_out     (last_out),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Idle at random, then present one pixel and hold it until the transfer
	task automatic send_pixel(input func_t f, input logic [PORT_W-1:0] a,
			input logic [PORT_W-1:0] b, input logic [PORT_W-1:0] c, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			idle_cycles++;
			@(posedge clk);
		end
		start       <= 1'b1;
		func        <= f;
		comp_a      <= a;
		comp_b      <= b;
		comp_c      <= c;
		last_sample <= last;
		do
			@(posedge clk);
		while (busy);
		func_count[f]++;
	endtask

	// Mix of extremes, small pixel values and full-range noise
	function automatic logic [PORT_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return S_MAX;
					1: return S_MIN;
					2: return S_NEG1;
					default: return '0;
				endcase
			end
			1, 2, 3, 4: return PORT_W'($signed($urandom_range(2047)) - 1024);
			5: return PORT_W'($signed($urandom_range(131071)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [PORT_W-1:0] corner[5][3];
		stall_count  = 0;
		idle_cycles  = 0;
		idle_pct     = 0;
		func_count   = '{default: 0};
		arst_n      <= 1'b0;
		start       <= 1'b0;
		func        <= FUNC_RCT_FWD;
		comp_a      <= '0;
		comp_b      <= '0;
		comp_c      <= '0;
		last_sample <= 1'b0;
		corner = '{
			'{'0, '0, '0},
			'{S_MAX, S_MAX, S_MAX},
			'{S_MIN, S_MIN, S_MIN},
			'{S_MAX, S_MIN, S_NEG1},
			'{S_NEG1, 32'd1, S_MIN}
		};

		// Hold reset, then release on a clock edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every transform against the sample extremes, back to back
		for (int f = 0; f < 4; f++)
			for (int v = 0; v < 5; v++)
				send_pixel(func_t'(f), corner[v][0], corner[v][1], corner[v][2],
					logic'((f + v) % 2));

		// Random: sender idles often, then more often, then not at all
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 34 : (phase == 1) ? 58 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				send_pixel(func_t'($urandom_range(3)), pick_sample(), pick_sample(),
					pick_sample(), ($urandom_range(7) == 0));
		end
		start <= 1'b0;

		// Drain the pipeline, then allow for stray results
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d pixels: RCT fwd %0d, RCT inv %0d, ICT fwd %0d, ICT inv %0d",
			func_count.sum(), func_count[0], func_count[1], func_count[2], func_count[3]);
		$display("Compared %0d results with %0d idle sender cycles, %0d mismatches",
			results_seen, idle_cycles, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
